// ===== src/assert_macros.svh =====
// Assertion macros for the checker module of this project.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/erq_pkg.sv =====
package erq_pkg;

	localparam int CAPACITY         = 64;
	localparam int INGREDIENT_COUNT = 16;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int ACC_W  = 64;
	localparam int CHR_W  = 64;
	localparam int ORD_W  = 8;
	localparam int QTY_W  = 31;
	localparam int TIME_W = 64;
	localparam int GEN_W  = 32;
	localparam int LIFE_W = 32;
	localparam int LIM_W  = 4;
	localparam int STAT_W = 4;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_POP     = 2'd1,
		OP_REQUEUE = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] ST_ENQUEUED     = 4'd0;
	localparam logic [STAT_W-1:0] ST_INVALID      = 4'd1;
	localparam logic [STAT_W-1:0] ST_FULL         = 4'd2;
	localparam logic [STAT_W-1:0] ST_POP_LIVE     = 4'd3;
	localparam logic [STAT_W-1:0] ST_POP_EXPIRED  = 4'd4;
	localparam logic [STAT_W-1:0] ST_EMPTY        = 4'd5;
	localparam logic [STAT_W-1:0] ST_CLEARED      = 4'd6;
	localparam logic [STAT_W-1:0] ST_REQUEUED     = 4'd7;
	localparam logic [STAT_W-1:0] ST_STALE        = 4'd8;
	localparam logic [STAT_W-1:0] ST_REQUEUE_FULL = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_LIFETIME     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_LIMIT = 1'd1;

	localparam logic [LIFE_W-1:0] LIFETIME_RESET = 32'd10000;
	localparam logic [LIM_W-1:0]  LIMIT_RESET    = 4'd8;

	typedef struct packed {
		logic [ACC_W-1:0]  account;
		logic [CHR_W-1:0]  character;
		logic [ORD_W-1:0]  ordinal;
		logic [QTY_W-1:0]  quantity;
		logic [TIME_W-1:0] created;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/expiring_ring_queue.sv =====
// Expiring ring queue: a bounded FIFO of timestamped notices held in one
// synchronous RAM of CAPACITY entries, each entry one packed word of ids,
// ordinal, quantity and creation time. An operation is accepted at a rising
// edge where start is high and busy is low, and its result word appears on the
// result ports, marked by done, for exactly one cycle: the cycle right after
// acceptance. The receiver cannot stall, and none is needed: while busy is low
// the block takes one operation every cycle, so a new start may follow in the
// cycle after the previous one. The result timing is set by the RAM read port:
// a pop issues its read of the head slot at acceptance and the registered read
// data is on the outputs in the next cycle, where the expiry check is made. busy
// is high in reset and falls at the first clock edge after release. Head,
// count, generation and the report counter live in flip-flops and are updated
// at acceptance, so back-to-back operations always see current pointers; a
// read and a write never come in the same cycle, because each operation either
// writes (enqueue, requeue) or reads (pop), never both.
// Configuration writes are always ready and should be made while no result is
// pending. Fields of the popped entry read as zero for every other status.
module expiring_ring_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic [erq_pkg::ACC_W-1:0]    account_id,
	input  logic [erq_pkg::CHR_W-1:0]    character_id,
	input  logic [erq_pkg::ORD_W-1:0]    ordinal,
	input  logic signed [31:0]           quantity,
	input  logic [erq_pkg::TIME_W-1:0]   now,
	input  logic [erq_pkg::TIME_W-1:0]   created_time,
	input  logic [erq_pkg::GEN_W-1:0]    gen_tag,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [erq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data,
	output logic                         done,
	output logic [erq_pkg::STAT_W-1:0]   status,
	output logic [erq_pkg::ACC_W-1:0]    out_account,
	output logic [erq_pkg::CHR_W-1:0]    out_character,
	output logic [erq_pkg::ORD_W-1:0]    out_ordinal,
	output logic [erq_pkg::QTY_W-1:0]    out_quantity,
	output logic [erq_pkg::TIME_W-1:0]   out_created,
	output logic [erq_pkg::GEN_W-1:0]    out_generation,
	output logic [erq_pkg::CNT_W-1:0]    occupancy,
	output logic                         warn
);

	import erq_pkg::*;

	// Configuration registers.
	logic [LIFE_W-1:0] lifetime_q;
	logic [LIM_W-1:0]  report_limit_q;

	// Ring control state.
	logic [IDX_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [GEN_W-1:0] gen_q, gen_d;
	logic [LIM_W-1:0] reports_q, reports_d;
	logic             busy_q;

	// Result stage, registered at acceptance.
	logic              done_s1;
	logic              pop_s1;
	logic [STAT_W-1:0] status_s1;
	logic              warn_s1;
	logic [TIME_W-1:0] now_s1;
	logic [GEN_W-1:0]  gen_s1;
	logic [CNT_W-1:0]  count_s1;

	logic              accept;
	logic              is_full;
	logic              fields_ok;
	logic              full_report;
	logic [STAT_W-1:0] status_d;
	logic              warn_d;
	logic              pop_d;

	logic             wr_en;
	logic             rd_en;
	logic [IDX_W-1:0] tail_idx;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W:0]   tail_sum;
	entry_t           wr_entry;
	entry_t           rd_entry;

	logic [TIME_W-1:0] age;
	logic              expired;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	assign is_full = (count_q == CNT_W'(CAPACITY));

	// An enqueue needs both ids, an ordinal inside the ingredient table and a
	// strictly positive quantity.
	assign fields_ok = (account_id != '0) && (character_id != '0)
		&& ({1'b0, ordinal} < 9'(INGREDIENT_COUNT))
		&& !quantity[31] && (quantity != '0);

	// A full event warns only while the running count stays under the limit.
	assign full_report = (reports_q < report_limit_q);

	// Tail slot is head plus count, wrapped once around the ring.
	assign tail_sum = {1'b0, head_q} + (IDX_W + 1)'(count_q);
	assign tail_idx = (tail_sum >= (IDX_W + 1)'(CAPACITY))
		? IDX_W'(tail_sum - (IDX_W + 1)'(CAPACITY)) : tail_sum[IDX_W-1:0];
	assign head_next = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		wr_entry.account   = account_id;
		wr_entry.character = character_id;
		wr_entry.ordinal   = ordinal;
		wr_entry.quantity  = quantity[QTY_W-1:0];
		wr_entry.created   = (op_t'(op) == OP_REQUEUE) ? created_time : now;
	end

	always_comb begin
		head_d    = head_q;
		count_d   = count_q;
		gen_d     = gen_q;
		reports_d = reports_q;
		status_d  = ST_ENQUEUED;
		warn_d    = 1'b0;
		pop_d     = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		case (op_t'(op))
			OP_ENQUEUE: begin
				if (!fields_ok) begin
					status_d = ST_INVALID;
				end else if (is_full) begin
					status_d = ST_FULL;
					warn_d   = full_report;
				end else begin
					status_d = ST_ENQUEUED;
					wr_en    = accept;
					count_d  = count_q + 1'b1;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					pop_d   = 1'b1;
					rd_en   = accept;
					head_d  = head_next;
					count_d = count_q - 1'b1;
				end
			end
			OP_REQUEUE: begin
				if (gen_tag != gen_q) begin
					status_d = ST_STALE;
				end else if (is_full) begin
					status_d = ST_REQUEUE_FULL;
					warn_d   = full_report;
				end else begin
					status_d = ST_REQUEUED;
					wr_en    = accept;
					count_d  = count_q + 1'b1;
				end
			end
			OP_CLEAR: begin
				status_d = ST_CLEARED;
				head_d   = '0;
				count_d  = '0;
				gen_d    = gen_q + 1'b1;
			end
			default: begin
				status_d = ST_INVALID;
			end
		endcase
		if (warn_d) begin
			reports_d = reports_q + 1'b1;
		end
	end

	erq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(tail_idx),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(head_q),
		.rdata(rd_entry)
	);

	// Configuration writes; an index past the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q     <= LIFETIME_RESET;
			report_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LIFETIME:     lifetime_q     <= cfg_data[LIFE_W-1:0];
				REG_REPORT_LIMIT: report_limit_q <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			head_q    <= '0;
			count_q   <= '0;
			gen_q     <= '0;
			reports_q <= '0;
			done_s1   <= 1'b0;
		end else begin
			busy_q  <= 1'b0;
			done_s1 <= accept;
			if (accept) begin
				head_q    <= head_d;
				count_q   <= count_d;
				gen_q     <= gen_d;
				reports_q <= reports_d;
			end
		end
	end

	// Result payload needs no reset; it is qualified by done.
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1    <= pop_d;
			status_s1 <= status_d;
			warn_s1   <= warn_d;
			now_s1    <= now;
			gen_s1    <= gen_d;
			count_s1  <= count_d;
		end
	end

	// Expired when the check time precedes creation or the age reached the
	// lifetime; a zero lifetime expires everything.
	assign age     = now_s1 - rd_entry.created;
	assign expired = (now_s1 < rd_entry.created) || (age >= TIME_W'(lifetime_q));

	assign done           = done_s1;
	assign status         = pop_s1 ? (expired ? ST_POP_EXPIRED : ST_POP_LIVE) : status_s1;
	assign out_account    = pop_s1 ? rd_entry.account   : '0;
	assign out_character  = pop_s1 ? rd_entry.character : '0;
	assign out_ordinal    = pop_s1 ? rd_entry.ordinal   : '0;
	assign out_quantity   = pop_s1 ? rd_entry.quantity  : '0;
	assign out_created    = pop_s1 ? rd_entry.created   : '0;
	assign out_generation = gen_s1;
	assign occupancy      = count_s1;
	assign warn           = warn_s1;

endmodule

// ===== src/erq_ram.sv =====
module erq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/erq_check.sv =====
`include "assert_macros.svh"

module erq_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [erq_pkg::STAT_W-1:0]    status,
	input logic [erq_pkg::ACC_W-1:0]     out_account,
	input logic [erq_pkg::TIME_W-1:0]    out_created,
	input logic [erq_pkg::CNT_W-1:0]     occupancy,
	input logic                          warn
);

	import erq_pkg::*;

	logic popped;
	logic full_status;

	assign popped      = (status == ST_POP_LIVE) || (status == ST_POP_EXPIRED);
	assign full_status = (status == ST_FULL) || (status == ST_REQUEUE_FULL);

	// Every accepted word yields exactly one result word in the next cycle.
	`ASSERT_NEXT(a_accept_done, start && !busy, done)
	`ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done)
	// Entry fields are only shown for a pop.
	`ASSERT_SAME(a_fields_zero, done && !popped, out_account == '0 && out_created == '0)
	// A clear leaves an empty ring; a warning comes only with a full event.
	`ASSERT_SAME(a_clear_empty, done && status == ST_CLEARED, occupancy == '0)
	`ASSERT_SAME(a_warn_full, done && warn, full_status)

endmodule

bind expiring_ring_queue erq_check u_erq_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.out_account(out_account),
	.out_created(out_created),
	.occupancy  (occupancy),
	.warn       (warn)
);
